// File: src/pmsr_pkg.sv
// Shared types and constants for the pointer motion scale and rotate block.
package pmsr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_EVENT_KIND  = 3'd0;
  localparam logic [2:0] REG_X_CODE      = 3'd1;
  localparam logic [2:0] REG_Y_CODE      = 3'd2;
  localparam logic [2:0] REG_GAIN_NUM    = 3'd3;
  localparam logic [2:0] REG_GAIN_DEN    = 3'd4;
  localparam logic [2:0] REG_ROT_ENABLE  = 3'd5;
  localparam logic [2:0] REG_COSINE      = 3'd6;
  localparam logic [2:0] REG_SINE        = 3'd7;

  localparam int CFG_DATA_W = 16;
  localparam int TRIG_W     = 11;
  localparam int GAIN_W     = 15;

  // Rotation products are scaled by this
  localparam logic [GAIN_W-1:0] MILLI_SCALE = 15'd1000;

  // Widths of the serial datapath
  localparam int ACC_W = 28;  // signed sum of two 16x11 products
  localparam int DVD_W = 27;  // dividend magnitude

  typedef struct packed {
    logic [7:0]         in_kind;
    logic [15:0]        in_code;
    logic signed [15:0] in_value;
  } event_beat_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               matched;
  } result_beat_t;

endpackage

// File: src/pointer_motion_scale_rotate.sv
// Pointer motion scaler and rotator with a bit-serial multiply and divide datapath.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------
//  event    | in        | event_valid / event_stall  | event_data  (event_beat_t)
//  result   | out       | result_valid / result_stall| result_data (result_beat_t)
//  config   | in        | cfg_write                  | cfg_index, cfg_data
//
// One event is in flight at a time. An unmatched event goes straight to S_DONE;
// scaling runs 15 multiply steps on the gain bits and 16 restoring divide steps,
// a paired rotation runs one setup, 22 multiply steps and 27 divide steps.
// These steps run on the single shift-add/subtract unit and the shared divider.
// Reset (rst, synchronous) clears state and loads register defaults.
// A finished result waits in the output register while the next event is taken.
module pointer_motion_scale_rotate
  import pmsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  event_valid,
  output logic                  event_stall,
  input  event_beat_t           event_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_beat_t          result_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SMUL = 3'd1;
  localparam logic [2:0] S_SDIV = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_RMUL = 3'd4;
  localparam logic [2:0] S_RDIV = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration
  logic [7:0]        event_kind;
  logic [15:0]       x_axis_code;
  logic [15:0]       y_axis_code;
  logic [GAIN_W-1:0] gain_numerator;
  logic [GAIN_W-1:0] gain_denominator;
  logic              rotate_enable;
  logic [TRIG_W-1:0] cosine_milli;
  logic [TRIG_W-1:0] sine_milli;

  // Axis state
  logic [15:0] held_x, held_y, carry_x, carry_y;
  logic        x_pending, y_pending;

  // Sequencer and datapath
  logic [2:0]        state;
  logic [4:0]        cnt;
  logic              is_x;
  logic              matched_r;
  logic [15:0]       val;
  logic [ACC_W-1:0]  acc, mcand;
  logic [15:0]       mbits;
  logic              msigned, mneg, phase;
  logic [DVD_W-1:0]  dvd;
  logic [GAIN_W-1:0] rem, divisor;
  logic              dsign;

  logic              accept;
  logic              hit_kind, hit_x, hit_y, scaling;
  logic              mul_sub;
  logic [ACC_W-1:0]  acc_step;
  logic [15:0]       trial;
  logic              div_ge;
  logic [GAIN_W-1:0] rem_step;
  logic [DVD_W-1:0]  dvd_step;
  logic [15:0]       carry_sel, vm, vm_mag;
  logic [ACC_W-1:0]  sum_mag;
  logic [DVD_W-1:0]  q_signed;
  logic [15:0]       r_signed;

  assign event_stall = (state != S_IDLE);
  assign accept      = event_valid && !event_stall;

  // Classify the incoming event
  assign hit_kind = (event_data.in_kind == event_kind);
  assign hit_x    = hit_kind && (event_data.in_code == x_axis_code);
  assign hit_y    = hit_kind && (event_data.in_code == y_axis_code);
  assign scaling  = (gain_numerator != '0) && (gain_denominator != '0);

  // One shift-add step; the sign bit of a signed multiplier subtracts
  assign mul_sub  = mneg ^ (msigned && (cnt == 5'd0));
  always_comb begin
    if (mbits[0]) begin
      acc_step = mul_sub ? (acc - mcand) : (acc + mcand);
    end else begin
      acc_step = acc;
    end
  end

  // One restoring divide step
  assign trial    = {rem, dvd[DVD_W-1]};
  assign div_ge   = (trial >= {1'b0, divisor});
  assign rem_step = div_ge ? GAIN_W'(trial - {1'b0, divisor}) : trial[GAIN_W-1:0];
  assign dvd_step = {dvd[DVD_W-2:0], div_ge};

  // Scaled value plus this axis' carry, and its magnitude
  assign carry_sel = is_x ? carry_x : carry_y;
  assign vm        = acc_step[15:0] + carry_sel;
  assign vm_mag    = vm[15] ? (16'd0 - vm) : vm;
  assign sum_mag   = acc_step[ACC_W-1] ? (ACC_W'(0) - acc_step) : acc_step;

  // Apply the dividend sign to quotient and remainder
  assign q_signed  = dsign ? (DVD_W'(0) - dvd_step) : dvd_step;
  assign r_signed  = dsign ? (16'd0 - {1'b0, rem_step}) : {1'b0, rem_step};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      event_kind       <= 8'd2;
      x_axis_code      <= 16'd0;
      y_axis_code      <= 16'd1;
      gain_numerator   <= 15'd1;
      gain_denominator <= 15'd1;
      rotate_enable    <= 1'b0;
      cosine_milli     <= 11'd1000;
      sine_milli       <= 11'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EVENT_KIND: event_kind       <= cfg_data[7:0];
        REG_X_CODE:     x_axis_code      <= cfg_data;
        REG_Y_CODE:     y_axis_code      <= cfg_data;
        REG_GAIN_NUM:   gain_numerator   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DEN:   gain_denominator <= cfg_data[GAIN_W-1:0];
        REG_ROT_ENABLE: rotate_enable    <= cfg_data[0];
        REG_COSINE:     cosine_milli     <= cfg_data[TRIG_W-1:0];
        REG_SINE:       sine_milli       <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control and axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      held_x       <= '0;
      held_y       <= '0;
      carry_x      <= '0;
      carry_y      <= '0;
      x_pending    <= 1'b0;
      y_pending    <= 1'b0;
    end else begin
      // Raise the beat when a result is loaded, drop it once taken
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!(hit_x || hit_y)) begin
              state <= S_DONE;
            end else if (scaling) begin
              state <= S_SMUL;
            end else if (rotate_enable) begin
              state <= S_ROT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SMUL: begin
          if (cnt == 5'd0) begin
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (cnt == 5'd0) begin
            if (is_x) begin
              carry_x <= r_signed;
            end else begin
              carry_y <= r_signed;
            end
            state <= rotate_enable ? S_ROT : S_DONE;
          end
        end
        S_ROT: begin
          // Store this axis and pair with the other if it waits
          if (is_x) begin
            held_x    <= val;
            x_pending <= 1'b1;
            if (y_pending) begin
              y_pending <= 1'b0;
            end
            state <= y_pending ? S_RMUL : S_DONE;
          end else begin
            held_y    <= val;
            y_pending <= 1'b1;
            if (x_pending) begin
              x_pending <= 1'b0;
            end
            state <= x_pending ? S_RMUL : S_DONE;
          end
        end
        S_RMUL: begin
          if (cnt == 5'd0 && phase) begin
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (cnt == 5'd0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the beat over once the output register is free
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        is_x      <= hit_x;
        matched_r <= hit_x || hit_y;
        val       <= event_data.in_value;
        acc       <= '0;
        mcand     <= ACC_W'(signed'(event_data.in_value));
        mbits     <= {1'b0, gain_numerator};
        msigned   <= 1'b0;
        mneg      <= 1'b0;
        cnt       <= 5'(GAIN_W - 1);
      end
      S_SMUL: begin
        acc   <= acc_step;
        mcand <= mcand << 1;
        mbits <= mbits >> 1;
        if (cnt == 5'd0) begin
          dsign   <= vm[15];
          dvd     <= {vm_mag, {(DVD_W - 16){1'b0}}};
          rem     <= '0;
          divisor <= gain_denominator;
          cnt     <= 5'd15;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      S_SDIV, S_RDIV: begin
        dvd <= dvd_step;
        rem <= rem_step;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          val <= q_signed[15:0];
        end
      end
      S_ROT: begin
        // First product: x term; the no-pair case emits zero
        acc     <= '0;
        mcand   <= is_x ? ACC_W'(signed'(val)) : ACC_W'(signed'(held_x));
        mbits   <= {5'd0, (is_x ? cosine_milli : sine_milli)};
        msigned <= 1'b1;
        mneg    <= 1'b0;
        phase   <= 1'b0;
        cnt     <= 5'(TRIG_W - 1);
        val     <= '0;
      end
      S_RMUL: begin
        acc <= acc_step;
        if (cnt == 5'd0) begin
          if (!phase) begin
            // Second product: y term, subtracted for the x output
            phase <= 1'b1;
            mcand <= ACC_W'(signed'(held_y));
            mbits <= {5'd0, (is_x ? sine_milli : cosine_milli)};
            mneg  <= is_x;
            cnt   <= 5'(TRIG_W - 1);
          end else begin
            dsign   <= acc_step[ACC_W-1];
            dvd     <= sum_mag[DVD_W-1:0];
            rem     <= '0;
            divisor <= MILLI_SCALE;
            cnt     <= 5'(DVD_W - 1);
          end
        end else begin
          mcand <= mcand << 1;
          mbits <= mbits >> 1;
          cnt   <= cnt - 5'd1;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_data.out_value <= val;
          result_data.matched   <= matched_r;
        end
      end
      default: ;
    endcase
  end

endmodule
